// ===== hdl/pimc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pimc_pkg
// Shared types and constants of the proposal IoU match / classify core.
// ----------------------------------------------------------------------------
package pimc_pkg;

  localparam int unsigned MAX_BOXES_DEF = 64;

  localparam int unsigned COORD_W = 16;
  localparam int unsigned AREA_W  = 32;
  localparam int unsigned CLASS_W = 12;
  localparam int unsigned IOU_W   = 17;
  localparam int unsigned MIDX_W  = 6;
  localparam int unsigned PAREA_W = 36;   // signed proposal area, Q27.8
  localparam int unsigned INTER_W = 34;   // intersection, Q26.8
  localparam int unsigned DIV_W   = 35;   // divider operand width
  localparam int unsigned QUO_W   = 16;

  localparam int unsigned IN_DATA_W  = 112;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 40;

  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_AW    = 1;

  localparam logic [COORD_W-1:0] ONE_PIXEL = 16'd16;
  localparam logic [IOU_W-1:0]   IOU_ONE   = 17'd65536;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_CLASS  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  localparam logic [1:0] CFG_FG     = 2'd0;
  localparam logic [1:0] CFG_BG_HI  = 2'd1;
  localparam logic [1:0] CFG_BG_LO  = 2'd2;

  typedef struct packed {
    logic [1:0]              op;
    logic [COORD_W-1:0]      x1;
    logic [COORD_W-1:0]      y1;
    logic [COORD_W-1:0]      x2;
    logic [COORD_W-1:0]      y2;
    logic [AREA_W-1:0]       area;
    logic [CLASS_W-1:0]      cls;
    logic signed [PAREA_W-1:0] parea;
  } cmd_t;

  typedef struct packed {
    logic [IOU_W-1:0] fg;
    logic [IOU_W-1:0] bg_hi;
    logic [IOU_W-1:0] bg_lo;
  } thr_t;

endpackage
`default_nettype wire

// ===== hdl/pimc_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pimc_front
// Accepts input transactions, computes proposal area, queues commands.
// ----------------------------------------------------------------------------
module pimc_front (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_valid_i,
  output logic                                  s_ready_o,
  input  wire logic [pimc_pkg::IN_DATA_W-1:0]   s_data_i,
  input  wire logic [pimc_pkg::IN_USER_W-1:0]   s_user_i,
  output logic                                  cmd_valid_o,
  input  wire logic                             cmd_ready_i,
  output pimc_pkg::cmd_t                        cmd_o
);
  import pimc_pkg::*;

  cmd_t              q_mem [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [Q_AW:0]     cnt_q, cnt_d;
  logic              push, pop;
  cmd_t              new_cmd;
  logic signed [17:0] dx, dy;
  logic signed [PAREA_W-1:0] parea;

  always_comb begin
    new_cmd.op   = s_user_i[1:0];
    new_cmd.x1   = s_data_i[15:0];
    new_cmd.y1   = s_data_i[31:16];
    new_cmd.x2   = s_data_i[47:32];
    new_cmd.y2   = s_data_i[63:48];
    new_cmd.area = s_data_i[95:64];
    new_cmd.cls  = s_data_i[107:96];
    dx = $signed({2'b0, new_cmd.x2}) - $signed({2'b0, new_cmd.x1})
       + $signed({2'b0, ONE_PIXEL});
    dy = $signed({2'b0, new_cmd.y2}) - $signed({2'b0, new_cmd.y1})
       + $signed({2'b0, ONE_PIXEL});
    parea = PAREA_W'(dx * dy);
    new_cmd.parea = parea;
  end

  assign s_ready_o   = (cnt_q != (Q_AW+1)'(Q_DEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = q_mem[rd_ptr_q];
  assign push        = s_valid_i && s_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + Q_AW'(1) : wr_ptr_q;
    rd_ptr_d = pop  ? rd_ptr_q + Q_AW'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + (Q_AW+1)'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - (Q_AW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= new_cmd;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/pimc_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pimc_div
// Restoring divider, one quotient bit per cycle; dividend < divisor.
// ----------------------------------------------------------------------------
module pimc_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [pimc_pkg::DIV_W-1:0]    num_i,
  input  wire logic [pimc_pkg::DIV_W-1:0]    den_i,
  output logic                               done_o,
  output logic [pimc_pkg::QUO_W-1:0]         quo_o
);
  import pimc_pkg::*;

  logic [DIV_W-1:0] rem_q, den_q;
  logic [QUO_W-1:0] quo_q;
  logic [4:0]       step_q;
  logic             busy_q, done_q;
  logic [DIV_W:0]   shifted;
  logic             take;

  assign shifted = {rem_q, 1'b0};
  assign take    = (shifted >= {1'b0, den_q});
  assign done_o  = done_q;
  assign quo_o   = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 5'd1;
        if (step_q == 5'(QUO_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      den_q <= den_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= take ? DIV_W'(shifted - {1'b0, den_q}) : shifted[DIV_W-1:0];
      quo_q <= {quo_q[QUO_W-2:0], take};
    end
  end

endmodule
`default_nettype wire

// ===== hdl/pimc_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pimc_back
// Box table and match engine: clear, append, scan with IoU per entry.
// ----------------------------------------------------------------------------
module pimc_back #(
  parameter int unsigned MAX_BOXES = pimc_pkg::MAX_BOXES_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cmd_valid_i,
  output logic                                 cmd_ready_o,
  input  wire pimc_pkg::cmd_t                  cmd_i,
  input  wire pimc_pkg::thr_t                  thr_i,
  output logic                                 m_valid_o,
  input  wire logic                            m_ready_i,
  output logic [pimc_pkg::OUT_DATA_W-1:0]      m_data_o
);
  import pimc_pkg::*;

  localparam int unsigned IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_BOXES + 1);
  localparam int unsigned ENT_W = 4 * COORD_W + AREA_W + CLASS_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_READ  = 4'd1;
  localparam logic [3:0] S_OVL   = 4'd2;
  localparam logic [3:0] S_MUL   = 4'd3;
  localparam logic [3:0] S_UNI   = 4'd4;
  localparam logic [3:0] S_DIVST = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_CMP   = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [ENT_W-1:0] mem [MAX_BOXES];
  logic [ENT_W-1:0] rd_q;
  logic             wr_en;

  logic [3:0]       state_q;
  logic [CNT_W-1:0] cnt_q, k_q;
  logic [COORD_W-1:0] px1_q, py1_q, px2_q, py2_q;
  logic signed [PAREA_W-1:0] parea_q;
  logic [IOU_W-1:0] best_q, v_q;
  logic [IDX_W-1:0] idx_q;
  logic [CLASS_W-1:0] cls_q;
  logic             found_q;
  logic [16:0]      w_q, h_q;
  logic [INTER_W-1:0] inter_q;
  logic signed [PAREA_W-1:0] uni_q;
  logic             m_valid_q;
  logic [OUT_DATA_W-1:0] m_data_q;

  logic [COORD_W-1:0] bx1, by1, bx2, by2, mnx, mxx, mny, mxy;
  logic [AREA_W-1:0]  barea;
  logic [CLASS_W-1:0] bcls;
  logic signed [17:0] wd, hd;
  logic               slot_free, div_start, div_done;
  logic [QUO_W-1:0]   quo;
  logic [IDX_W+MIDX_W-1:0] idx_ext;
  logic               fg, bg;

  assign bx1   = rd_q[15:0];
  assign by1   = rd_q[31:16];
  assign bx2   = rd_q[47:32];
  assign by2   = rd_q[63:48];
  assign barea = rd_q[95:64];
  assign bcls  = rd_q[107:96];

  always_comb begin
    mnx = (px2_q < bx2) ? px2_q : bx2;
    mxx = (px1_q > bx1) ? px1_q : bx1;
    mny = (py2_q < by2) ? py2_q : by2;
    mxy = (py1_q > by1) ? py1_q : by1;
    wd  = $signed({2'b0, mnx}) - $signed({2'b0, mxx}) + $signed({2'b0, ONE_PIXEL});
    hd  = $signed({2'b0, mny}) - $signed({2'b0, mxy}) + $signed({2'b0, ONE_PIXEL});
  end

  assign cmd_ready_o = (state_q == S_IDLE);
  assign wr_en = cmd_valid_i && cmd_ready_o && (cmd_i.op == OP_APPEND)
              && (cnt_q < CNT_W'(MAX_BOXES));
  assign slot_free = !m_valid_q || m_ready_i;
  assign div_start = (state_q == S_DIVST) && (uni_q > 0) && (inter_q != '0)
                  && ({1'b0, inter_q} < uni_q[DIV_W-1:0]);
  assign idx_ext = {{MIDX_W{1'b0}}, idx_q};
  assign fg = (best_q >= thr_i.fg);
  assign bg = (best_q < thr_i.bg_hi) && (best_q >= thr_i.bg_lo);
  assign m_valid_o = m_valid_q;
  assign m_data_o  = m_data_q;

  pimc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   ({1'b0, inter_q}),
    .den_i   (uni_q[DIV_W-1:0]),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[cnt_q[IDX_W-1:0]] <= {cmd_i.cls, cmd_i.area, cmd_i.y2, cmd_i.x2,
                                cmd_i.y1, cmd_i.x1};
    end
    rd_q <= mem[k_q[IDX_W-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (state_q == S_DONE && slot_free) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_ready_i) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            if (cmd_i.op == OP_CLEAR) begin
              cnt_q <= '0;
            end else if (wr_en) begin
              cnt_q <= cnt_q + CNT_W'(1);
            end else if (cmd_i.op == OP_CLASS) begin
              state_q <= (cnt_q == '0) ? S_DONE : S_READ;
            end
          end
        end
        S_READ:  state_q <= S_OVL;
        S_OVL:   state_q <= S_MUL;
        S_MUL:   state_q <= S_UNI;
        S_UNI:   state_q <= S_DIVST;
        S_DIVST: state_q <= div_start ? S_DIV : S_CMP;
        S_DIV: begin
          if (div_done) begin
            state_q <= S_CMP;
          end
        end
        S_CMP: begin
          state_q <= (k_q + CNT_W'(1) == cnt_q) ? S_DONE : S_READ;
        end
        S_DONE: begin
          if (slot_free) begin
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        px1_q   <= cmd_i.x1;
        py1_q   <= cmd_i.y1;
        px2_q   <= cmd_i.x2;
        py2_q   <= cmd_i.y2;
        parea_q <= cmd_i.parea;
        k_q     <= '0;
        best_q  <= '0;
        idx_q   <= '0;
        cls_q   <= '0;
        found_q <= 1'b0;
      end
      S_OVL: begin
        w_q <= wd[17] ? 17'd0 : wd[16:0];
        h_q <= hd[17] ? 17'd0 : hd[16:0];
      end
      S_MUL: inter_q <= INTER_W'(w_q * h_q);
      S_UNI: begin
        uni_q <= parea_q + $signed({{(PAREA_W-AREA_W){1'b0}}, barea})
               - $signed({{(PAREA_W-INTER_W){1'b0}}, inter_q});
      end
      S_DIVST: begin
        // non-positive union or empty overlap gives zero; dividend not
        // below divisor saturates at one
        if (uni_q <= 0 || inter_q == '0) begin
          v_q <= '0;
        end else if ({1'b0, inter_q} >= uni_q[DIV_W-1:0]) begin
          v_q <= IOU_ONE;
        end
      end
      S_DIV: begin
        if (div_done) begin
          v_q <= {1'b0, quo};
        end
      end
      S_CMP: begin
        if (v_q > best_q) begin
          best_q  <= v_q;
          idx_q   <= k_q[IDX_W-1:0];
          cls_q   <= bcls;
          found_q <= 1'b1;
        end
        k_q <= k_q + CNT_W'(1);
      end
      S_DONE: begin
        if (slot_free) begin
          m_data_q <= {2'b0, bg, fg, cls_q, found_q, idx_ext[MIDX_W-1:0], best_q};
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/proposal_iou_match_classify_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// proposal_iou_match_classify_core
// Ground-truth box table with IoU matching and fg/bg labeling of proposals.
// ----------------------------------------------------------------------------
// Usage:
//  - s_axis: one transaction per command, op in tuser. Clear empties the
//    table, append stores a box (dropped when full), classify scans it.
//  - m_axis: one transaction per classify: best IoU, index, class, flags.
//  - cfg: threshold writes, index 0 fg, 1 bg high, 2 bg low; always ready.
//    Write only while no command is in flight.
//  - Clear/append are done by the engine straight from its idle state.
//  - Classify scans the stored boxes in turn, and waits on the serial
//    16-bit divider for each box whose IoU needs it (zero and saturated
//    IoUs skip it). The divider gives one quotient bit per cycle.
//  - A 2-entry command queue lets new transactions be taken while the
//    engine scans; the result register holds the result while m_axis
//    stalls, and the engine waits there before the next command.
//  - Reset empties the table count, the queue and the result register and
//    loads threshold defaults (0.5, 0.5, 0.0). Table contents need no init.
// ----------------------------------------------------------------------------
module proposal_iou_match_classify_core #(
  parameter int unsigned MAX_BOXES = pimc_pkg::MAX_BOXES_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // left_x[15:0] top_y[31:16] right_x[47:32] bottom_y[63:48]
  // box_area[95:64] box_class[107:96], zero pad
  input  wire logic [pimc_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  // op[1:0]
  input  wire logic [pimc_pkg::IN_USER_W-1:0]  s_axis_tuser_i,
  output logic                                 m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i,
  // best_iou[16:0] match_index[22:17] matched[23] match_class[35:24]
  // is_foreground[36] is_background[37], zero pad
  output logic [pimc_pkg::OUT_DATA_W-1:0]      m_axis_tdata_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [1:0]                      cfg_index_i,
  input  wire logic [pimc_pkg::IOU_W-1:0]      cfg_data_i
);
  import pimc_pkg::*;

  thr_t thr_q;
  cmd_t cmd;
  logic cmd_valid, cmd_ready;

  assign cfg_ready_o = 1'b1;

  // threshold registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q.fg    <= 17'd32768;
      thr_q.bg_hi <= 17'd32768;
      thr_q.bg_lo <= 17'd0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_FG:    thr_q.fg    <= cfg_data_i;
        CFG_BG_HI: thr_q.bg_hi <= cfg_data_i;
        CFG_BG_LO: thr_q.bg_lo <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // front: accepts and queues commands, precomputes proposal area
  pimc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid_i),
    .s_ready_o   (s_axis_tready_o),
    .s_data_i    (s_axis_tdata_i),
    .s_user_i    (s_axis_tuser_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  // back: table storage and the per-box IoU scan
  pimc_back #(
    .MAX_BOXES (MAX_BOXES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .thr_i       (thr_q),
    .m_valid_o   (m_axis_tvalid_o),
    .m_ready_i   (m_axis_tready_i),
    .m_data_o    (m_axis_tdata_o)
  );

  // result consistency checks
  logic [IOU_W-1:0]   a_iou;
  logic [MIDX_W-1:0]  a_idx;
  logic [CLASS_W-1:0] a_cls;
  logic               a_matched, a_fg;

  assign a_iou     = m_axis_tdata_o[16:0];
  assign a_idx     = m_axis_tdata_o[22:17];
  assign a_matched = m_axis_tdata_o[23];
  assign a_cls     = m_axis_tdata_o[35:24];
  assign a_fg      = m_axis_tdata_o[36];

  a_unmatched_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !a_matched |-> a_idx == '0 && a_cls == '0 && a_iou == '0)
    else $error("unmatched result carries nonzero fields");

  a_matched_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && a_matched |-> a_iou != '0 && a_iou <= IOU_ONE)
    else $error("matched result with bad IoU");

  a_fg_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> a_fg == (a_iou >= thr_q.fg))
    else $error("foreground flag disagrees with threshold");

endmodule
`default_nettype wire

// ===== test/tb_proposal_iou_match_classify_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_proposal_iou_match_classify_core
// Streams clear / append / classify commands and threshold writes into the core, predicts each
// classify result with a local IoU matcher and checks every result field.
// ----------------------------------------------------------------------------
module tb_proposal_iou_match_classify_core;
  import pimc_pkg::*;

  localparam int unsigned TBL_DEPTH  = 64;
  localparam int unsigned WDOG_LIMIT = 200000;  // > one full 64-box scan x many
  localparam int unsigned DRAIN_CYC  = 2000;    // drain wait, longer than a full-table scan

  // One queued command, or a configuration write.
  typedef struct {
    logic        is_cfg;
    logic [1:0]  cfg_idx;
    logic [16:0] cfg_val;
    logic        hold;      // wait until all results are back first
    op_e         op;
    logic [15:0] x1, y1, x2, y2;
    logic [31:0] area;
    logic [11:0] cls;
  } cmd_s;

  typedef struct packed {
    logic [16:0] iou;
    logic [5:0]  idx;
    logic        matched;
    logic [11:0] cls;
    logic        fg;
    logic        bg;
  } match_s;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [IN_DATA_W-1:0] s_axis_tdata_i = '0;
  logic [IN_USER_W-1:0] s_axis_tuser_i = '0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i = '0;
  logic [IOU_W-1:0] cfg_data_i = '0;

  proposal_iou_match_classify_core u_dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Predictor state: shadow box table and thresholds.
  logic [15:0] gt_x1[TBL_DEPTH], gt_y1[TBL_DEPTH], gt_x2[TBL_DEPTH], gt_y2[TBL_DEPTH];
  logic [31:0] gt_area[TBL_DEPTH];
  logic [11:0] gt_cls[TBL_DEPTH];
  int unsigned gt_count = 0;
  logic [16:0] thr_fg = 17'd32768, thr_bg_hi = 17'd32768, thr_bg_lo = 17'd0;

  cmd_s   cmd_q[$];
  match_s match_q[$];
  int     errors = 0;

  // Queue append helpers.
  task automatic add_cmd(input cmd_s c);
    cmd_q = {cmd_q, c};
  endtask

  task automatic add_match(input match_s m);
    match_q = {match_q, m};
  endtask

  function automatic logic [16:0] box_iou(input logic [15:0] ax1, ay1, ax2, ay2,
                                          input longint a_area, input int k);
    longint w, h, inter, uni, q;
    longint lo, hi;
    lo = (ax1 > gt_x1[k]) ? ax1 : gt_x1[k];
    hi = (ax2 < gt_x2[k]) ? ax2 : gt_x2[k];
    w = hi - lo + 16;
    lo = (ay1 > gt_y1[k]) ? ay1 : gt_y1[k];
    hi = (ay2 < gt_y2[k]) ? ay2 : gt_y2[k];
    h = hi - lo + 16;
    if (w < 0) w = 0;
    if (h < 0) h = 0;
    inter = w * h;
    uni = a_area + longint'(gt_area[k]) - inter;
    if (uni <= 0 || inter == 0) return 17'd0;
    q = (inter * 65536) / uni;
    return (q > 65536) ? 17'd65536 : q[16:0];
  endfunction

  // Apply one accepted command to the shadow table; classify yields a result.
  task automatic predict_cmd(input cmd_s c);
    match_s m;
    longint a_area;
    logic [16:0] v;
    case (c.op)
      OP_CLEAR: gt_count = 0;
      OP_APPEND: begin
        if (gt_count < TBL_DEPTH) begin
          gt_x1[gt_count] = c.x1; gt_y1[gt_count] = c.y1;
          gt_x2[gt_count] = c.x2; gt_y2[gt_count] = c.y2;
          gt_area[gt_count] = c.area; gt_cls[gt_count] = c.cls;
          gt_count++;
        end
      end
      OP_CLASS: begin
        m = '0;
        a_area = (longint'(c.x2) - longint'(c.x1) + 16) *
                 (longint'(c.y2) - longint'(c.y1) + 16);
        for (int k = 0; k < gt_count; k++) begin
          v = box_iou(c.x1, c.y1, c.x2, c.y2, a_area, k);
          if (v > m.iou) begin
            m.iou = v; m.idx = k[5:0]; m.cls = gt_cls[k]; m.matched = 1'b1;
          end
        end
        m.fg = (m.iou >= thr_fg);
        m.bg = (m.iou < thr_bg_hi) && (m.iou >= thr_bg_lo);
        add_match(m);
      end
      default: ;  // unused op: ignored
    endcase
  endtask

  // ---------------- driver ----------------
  cmd_s cur;
  bit   have_cur = 0;
  int   gap = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      // retire accepted transactions
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        predict_cmd(cur);
        have_cur = 0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cur.cfg_idx)
          CFG_FG:    thr_fg    = cur.cfg_val;
          CFG_BG_HI: thr_bg_hi = cur.cfg_val;
          default:   thr_bg_lo = cur.cfg_val;
        endcase
        have_cur = 0;
      end
      if (!have_cur && cmd_q.size() > 0 && gap == 0) begin
        cur = cmd_q.pop_front();
        have_cur = 1;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
        if ($urandom_range(0, 4) == 0) gap = 0;
      end else if (!have_cur && gap > 0) begin
        gap--;
      end
      // config and held commands wait for an idle engine
      if (have_cur && (cur.is_cfg || cur.hold) && match_q.size() != 0) begin
        s_axis_tvalid_i <= 1'b0;
        cfg_valid_i     <= 1'b0;
      end else if (have_cur && cur.is_cfg) begin
        s_axis_tvalid_i <= 1'b0;
        cfg_valid_i     <= 1'b1;
        cfg_index_i     <= cur.cfg_idx;
        cfg_data_i      <= cur.cfg_val;
      end else if (have_cur) begin
        cfg_valid_i     <= 1'b0;
        s_axis_tvalid_i <= 1'b1;
        s_axis_tuser_i  <= cur.op;
        s_axis_tdata_i  <= {4'd0, cur.cls, cur.area, cur.y2, cur.x2, cur.y1, cur.x1};
      end else begin
        s_axis_tvalid_i <= 1'b0;
        cfg_valid_i     <= 1'b0;
      end
    end
  end

  // ---------------- monitor ----------------
  int stall = 0;
  always @(posedge clk_i) begin
    match_s got, want;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got.iou = m_axis_tdata_o[16:0];
        got.idx = m_axis_tdata_o[22:17];
        got.matched = m_axis_tdata_o[23];
        got.cls = m_axis_tdata_o[35:24];
        got.fg = m_axis_tdata_o[36];
        got.bg = m_axis_tdata_o[37];
        if (match_q.size() == 0) begin
          $error("unexpected result %h", m_axis_tdata_o);
          errors++;
        end else begin
          want = match_q.pop_front();
          if (got.iou != want.iou) begin
            $error("best_iou exp %0d got %0d", want.iou, got.iou); errors++;
          end
          if (got.idx != want.idx) begin
            $error("match_index exp %0d got %0d", want.idx, got.idx); errors++;
          end
          if (got.matched != want.matched) begin
            $error("matched exp %0d got %0d", want.matched, got.matched); errors++;
          end
          if (got.cls != want.cls) begin
            $error("match_class exp %0d got %0d", want.cls, got.cls); errors++;
          end
          if (got.fg != want.fg) begin
            $error("is_foreground exp %0d got %0d", want.fg, got.fg); errors++;
          end
          if (got.bg != want.bg) begin
            $error("is_background exp %0d got %0d", want.bg, got.bg); errors++;
          end
        end
        stall = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 18);
      end else if (stall > 0) begin
        stall--;
      end
      m_axis_tready_i <= (stall == 0) || (stall == 1 && !m_axis_tvalid_o);
    end
  end

  // ---------------- watchdog ----------------
  int idle_cyc = 0;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cyc <= 0;
    else
      idle_cyc <= idle_cyc + 1;
    if (idle_cyc >= WDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------- stimulus ----------------
  function automatic cmd_s mk_cmd(input op_e op, input logic [15:0] x1, y1, x2, y2,
                                  input logic [31:0] area, input logic [11:0] cls);
    cmd_s c;
    c.is_cfg = 0; c.cfg_idx = CFG_FG; c.cfg_val = '0; c.hold = 0;
    c.op = op; c.x1 = x1; c.y1 = y1; c.x2 = x2; c.y2 = y2; c.area = area; c.cls = cls;
    return c;
  endfunction

  task automatic push_cfg(input logic [1:0] idx, input logic [16:0] val);
    cmd_s c;
    c = mk_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0);
    c.is_cfg = 1; c.cfg_idx = idx; c.cfg_val = val;
    add_cmd(c);
  endtask

  // Box whose area mostly matches its coordinates, so IoUs spread over the range.
  function automatic cmd_s rand_box(input op_e op, input bit wide);
    logic [15:0] x1, y1, w, h;
    logic [31:0] a;
    w = wide ? 16'($urandom) : 16'($urandom_range(0, 2047));
    h = wide ? 16'($urandom) : 16'($urandom_range(0, 2047));
    x1 = wide ? 16'($urandom) : 16'($urandom_range(0, 4095));
    y1 = wide ? 16'($urandom) : 16'($urandom_range(0, 4095));
    a = (32'(w) + 16) * (32'(h) + 16);
    if ($urandom_range(0, 7) == 0) a = $urandom;
    return mk_cmd(op, x1, y1, x1 + w, y1 + h, a, 12'($urandom));
  endfunction

  initial begin
    cmd_s c;
    int n;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty table, extremes, ties, inverted boxes, unused op, full table.
    add_cmd(mk_cmd(OP_CLASS, 0, 0, 16'hFFFF, 16'hFFFF, 0, 0));
    add_cmd(mk_cmd(OP_APPEND, 0, 0, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 12'hFFF));
    add_cmd(mk_cmd(OP_APPEND, 16, 16, 31, 31, 256, 12'h5A5));
    add_cmd(mk_cmd(OP_APPEND, 16, 16, 31, 31, 256, 12'h0A1));  // tie
    add_cmd(mk_cmd(OP_APPEND, 100, 100, 50, 50, 0, 12'h222));  // neg area
    add_cmd(mk_cmd(OP_CLASS, 16, 16, 31, 31, 0, 0));
    add_cmd(mk_cmd(OP_CLASS, 0, 0, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 12'hFFF));
    add_cmd(mk_cmd(OP_CLASS, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0));  // inverted corners
    add_cmd(mk_cmd(OP_CLASS, 16'h8000, 16'h8000, 16'h8001, 16'h8001, 0, 0));
    add_cmd(mk_cmd(OP_NONE, 1, 2, 3, 4, 5, 6));
    add_cmd(mk_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0));
    add_cmd(mk_cmd(OP_CLASS, 16, 16, 31, 31, 0, 0));
    for (int i = 0; i < 66; i++) add_cmd(rand_box(OP_APPEND, 0));  // overflow
    add_cmd(rand_box(OP_CLASS, 0));
    c = rand_box(OP_CLASS, 0); c.hold = 1;  // sender waits for all results to come back
    add_cmd(c);

    // Random phases, each with its own threshold setting.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin push_cfg(CFG_FG, 17'd65536); push_cfg(CFG_BG_HI, 17'd65536);
                 push_cfg(CFG_BG_LO, 17'd0); end
        1: begin push_cfg(CFG_FG, 17'd0); push_cfg(CFG_BG_HI, 17'd0);
                 push_cfg(CFG_BG_LO, 17'd65536); end
        2: begin push_cfg(CFG_FG, 17'h1FFFF); push_cfg(CFG_BG_HI, 17'h1FFFF);
                 push_cfg(CFG_BG_LO, 17'h1FFFF); end
        default: begin
          push_cfg(CFG_FG, 17'($urandom_range(0, 65536)));
          push_cfg(CFG_BG_HI, 17'($urandom_range(0, 65536)));
          push_cfg(CFG_BG_LO, 17'($urandom_range(0, 32768)));
        end
      endcase
      n = 0;
      while (n < 180) begin
        // Mostly: fresh small table, then a burst of proposals.
        add_cmd(mk_cmd(OP_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom),
                       16'($urandom), $urandom, 12'($urandom)));
        n++;
        for (int b = $urandom_range(0, 6); b > 0; b--) begin
          add_cmd(rand_box(OP_APPEND, $urandom_range(0, 9) == 0)); n++;
        end
        for (int p = $urandom_range(1, 8); p > 0; p--) begin
          c = rand_box($urandom_range(0, 19) == 0 ? OP_NONE : OP_CLASS,
                       $urandom_range(0, 9) == 0);
          add_cmd(c); n++;
        end
      end
    end
    // Last phase restores defaults and classifies against a full table.
    push_cfg(CFG_FG, 17'd32768); push_cfg(CFG_BG_HI, 17'd32768); push_cfg(CFG_BG_LO, 0);
    add_cmd(mk_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0));
    for (int i = 0; i < 64; i++) add_cmd(rand_box(OP_APPEND, 0));
    for (int i = 0; i < 4; i++) add_cmd(rand_box(OP_CLASS, 0));

    wait (cmd_q.size() == 0 && !have_cur);
    wait (match_q.size() == 0);
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (errors == 0 && match_q.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// ===== proposal_iou_match_classify_core.f =====
hdl/pimc_pkg.sv
hdl/pimc_front.sv
hdl/pimc_div.sv
hdl/pimc_back.sv
hdl/proposal_iou_match_classify_core.sv
test/tb_proposal_iou_match_classify_core.sv
